// File: rtl/core/assert_macros.svh
// Assertion macros used by the top level of the scaler block.
// No dependencies; include before the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ISC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("isc assertion failed");

// Check that a condition implies another in the next cycle.
`define ISC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("isc assertion failed");

`endif

// File: rtl/core/isc_pkg.sv
// Shared types, widths and helpers of the image scale and composite block.
// No dependencies.
package isc_pkg;

  localparam int COORD_W    = 10;
  localparam int SRC_DIM_W  = 8;
  localparam int OUT_DIM_W  = 11;
  localparam int WIN_W      = 19;
  localparam int OFS_W      = 20;
  localparam int DIV_W      = COORD_W + WIN_W;
  localparam int GMAG_W     = 19;
  localparam int SX_W       = DIV_W + 2;
  localparam int NUM_W      = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [1:0]  MODE_COVER        = 2'd0;
  localparam logic [1:0]  MODE_ICON         = 2'd2;
  localparam logic [7:0]  ALPHA_OPAQUE      = 8'hFF;
  localparam logic [7:0]  ALPHA_CLEAR       = 8'h00;
  localparam logic [10:0] GRAD_SPAN_DEFAULT = 11'd240;

  localparam logic [23:0] RGB565_RED_MASK   = 24'h00F800;
  localparam logic [23:0] RGB565_GREEN_MASK = 24'h0007E0;
  localparam logic [23:0] RGB565_BLUE_MASK  = 24'h00001F;

  typedef struct packed {
    logic               action;
    logic [6:0]         src_col;
    logic [6:0]         src_row;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
    logic [COORD_W-1:0] out_col;
    logic [COORD_W-1:0] out_row;
  } in_item_t;

  typedef struct packed {
    logic [15:0] pixel_rgb565;
    logic        in_margin;
  } out_item_t;

  typedef struct packed {
    logic [SRC_DIM_W-1:0]   dw;
    logic [SRC_DIM_W-1:0]   dh;
    logic [OUT_DIM_W-1:0]   ow;
    logic [OUT_DIM_W-1:0]   oh;
    logic [WIN_W-1:0]       usew;
    logic [WIN_W-1:0]       useh;
    logic [OFS_W-1:0]       ox;
    logic [OFS_W-1:0]       oy;
    logic [OUT_DIM_W-1:0]   span;
    logic [COORD_W-1:0]     row_ofs;
    logic [CFG_DATA_W-1:0]  colors;
    logic [1:0]             mode;
    logic                   empty;
  } geom_t;

  typedef struct packed {
    logic        render;
    logic        we;
    logic        outside;
    logic [23:0] bg;
    logic [31:0] wdata;
  } front_t;

  function automatic logic [15:0] pack565(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    logic [23:0] rgb;
    rgb = {r, g, b};
    return 16'(((rgb >> 8) & RGB565_RED_MASK) | ((rgb >> 5) & RGB565_GREEN_MASK) |
               ((rgb >> 3) & RGB565_BLUE_MASK));
  endfunction

endpackage

// File: rtl/core/isc_if.sv
// Handshake channel interfaces: pixel input, pixel output, configuration writes.
// Depends on isc_pkg.
interface isc_in_if;
  import isc_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface isc_out_if;
  import isc_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface isc_cfg_if;
  import isc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

// File: rtl/core/isc_setup.sv
// Configuration registers and window setup sequencer (serial divider).
// Depends on isc_pkg and isc_if.
module isc_setup #(
  parameter int SOURCE_WIDTH_MAX  = 128,
  parameter int SOURCE_HEIGHT_MAX = 128,
  parameter int OUTPUT_DIM_MAX    = 1024
) (
  input  logic          clk,
  input  logic          rst,
  isc_cfg_if.sink       cfg,
  output isc_pkg::geom_t geom,
  output logic          busy
);
  import isc_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  typedef enum logic [1:0] {S_IDLE, S_PREP, S_DIV, S_FIN} state_t;
  typedef enum logic [2:0] {
    REG_GRAD_COLORS, REG_GRAD_ROW_OFFSET, REG_GRAD_SPAN_ROWS, REG_SOURCE_WIDTH,
    REG_SOURCE_HEIGHT, REG_OUTPUT_WIDTH, REG_OUTPUT_HEIGHT, REG_SCALE_MODE
  } cfg_reg_t;

  state_t                state;
  logic [CFG_DATA_W-1:0] colors;
  logic [COORD_W-1:0]    row_ofs;
  logic [10:0]           span_rows;
  logic [7:0]            src_w;
  logic [7:0]            src_h;
  logic [10:0]           out_w;
  logic [10:0]           out_h;
  logic [1:0]            mode;
  logic                  use_x;
  logic [11:0]           rem;
  logic [NUM_W-1:0]      quo;
  logic [CNT_W-1:0]      cnt;
  logic [WIN_W-1:0]      usew;
  logic [WIN_W-1:0]      useh;
  logic [OFS_W-1:0]      ox;
  logic [OFS_W-1:0]      oy;

  logic [SRC_DIM_W-1:0]  dw, dh;
  logic [OUT_DIM_W-1:0]  ow, oh, span;
  logic [18:0]           prod_a, prod_b;
  logic                  use_x_c;
  logic [NUM_W-1:0]      num_c;
  logic [11:0]           den;
  logic [12:0]           trial;
  logic                  ge;
  logic [WIN_W-1:0]      usew_c, useh_c;
  logic [20:0]           diffx, diffy, adjx, adjy;

  assign cfg.ready = 1'b1;
  assign busy = (state != S_IDLE);

  always_comb begin
    dw = ({24'd0, src_w} > SOURCE_WIDTH_MAX) ? SRC_DIM_W'(SOURCE_WIDTH_MAX) : src_w;
    dh = ({24'd0, src_h} > SOURCE_HEIGHT_MAX) ? SRC_DIM_W'(SOURCE_HEIGHT_MAX) : src_h;
    if (out_w == '0) begin
      ow = OUT_DIM_W'(1);
    end else if ({21'd0, out_w} > OUTPUT_DIM_MAX) begin
      ow = OUT_DIM_W'(OUTPUT_DIM_MAX);
    end else begin
      ow = out_w;
    end
    if (out_h == '0) begin
      oh = OUT_DIM_W'(1);
    end else if ({21'd0, out_h} > OUTPUT_DIM_MAX) begin
      oh = OUT_DIM_W'(OUTPUT_DIM_MAX);
    end else begin
      oh = out_h;
    end
    span = (span_rows < 11'd2) ? (GRAD_SPAN_DEFAULT - 11'd1) : (span_rows - 11'd1);
    prod_a = dw * oh;
    prod_b = dh * ow;
    use_x_c = (mode == MODE_COVER) ? (prod_a < prod_b) : (prod_a > prod_b);
    num_c = use_x_c ? ({prod_a, 1'b0} + {9'd0, ow}) : ({prod_b, 1'b0} + {9'd0, oh});
    den = use_x ? {ow, 1'b0} : {oh, 1'b0};
    trial = {rem, quo[NUM_W-1]};
    ge = (trial >= {1'b0, den});
    usew_c = use_x ? {11'd0, dw} : quo[WIN_W-1:0];
    useh_c = use_x ? quo[WIN_W-1:0] : {11'd0, dh};
    diffx = {13'd0, dw} - {2'd0, usew_c};
    diffy = {13'd0, dh} - {2'd0, useh_c};
    adjx = diffx + {20'd0, diffx[20]};
    adjy = diffy + {20'd0, diffy[20]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_PREP;
      colors    <= '0;
      row_ofs   <= '0;
      span_rows <= GRAD_SPAN_DEFAULT;
      src_w     <= '0;
      src_h     <= '0;
      out_w     <= 11'd1;
      out_h     <= 11'd1;
      mode      <= MODE_COVER;
      cnt       <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_GRAD_COLORS:     colors    <= cfg.wdata;
        REG_GRAD_ROW_OFFSET: row_ofs   <= cfg.wdata[COORD_W-1:0];
        REG_GRAD_SPAN_ROWS:  span_rows <= cfg.wdata[10:0];
        REG_SOURCE_WIDTH:    src_w     <= cfg.wdata[7:0];
        REG_SOURCE_HEIGHT:   src_h     <= cfg.wdata[7:0];
        REG_OUTPUT_WIDTH:    out_w     <= cfg.wdata[10:0];
        REG_OUTPUT_HEIGHT:   out_h     <= cfg.wdata[10:0];
        REG_SCALE_MODE:      mode      <= cfg.wdata[1:0];
      endcase
      state <= S_PREP;
    end else begin
      unique case (state)
        S_IDLE: begin
        end
        S_PREP: begin
          use_x <= use_x_c;
          quo   <= num_c;
          rem   <= '0;
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= ge ? 12'(trial - {1'b0, den}) : trial[11:0];
          quo <= {quo[NUM_W-2:0], ge};
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(NUM_W - 1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          usew  <= usew_c;
          useh  <= useh_c;
          ox    <= adjx[20:1];
          oy    <= adjy[20:1];
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign geom = '{dw: dw, dh: dh, ow: ow, oh: oh, usew: usew, useh: useh, ox: ox, oy: oy,
                  span: span, row_ofs: row_ofs, colors: colors, mode: mode,
                  empty: (dw == '0) || (dh == '0)};

endmodule

// File: rtl/core/isc_div_pipe.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on nothing; the user must hold the divisor static while items flow (not enforced here).
module isc_div_pipe #(
  parameter int N = 29,
  parameter int D = 11
) (
  input  logic         clk,
  input  logic         en,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  output logic [N-1:0] quotient
);
  logic [D-1:0] rem_q [1:N-1];
  logic [N-1:0] nq_q  [1:N];
  logic [D-1:0] rem_s [0:N-1];
  logic [N-1:0] nq_s  [0:N-1];
  logic [D:0]   trial [0:N-1];
  logic         ge    [0:N-1];
  logic [D-1:0] rem_n [0:N-1];
  logic [N-1:0] nq_n  [0:N-1];

  always_comb begin
    rem_s[0] = '0;
    nq_s[0]  = dividend;
    for (int k = 1; k < N; k++) begin
      rem_s[k] = rem_q[k];
      nq_s[k]  = nq_q[k];
    end
    for (int k = 0; k < N; k++) begin
      trial[k] = {rem_s[k], nq_s[k][N-1]};
      ge[k]    = (trial[k] >= {1'b0, divisor});
      rem_n[k] = ge[k] ? D'(trial[k] - {1'b0, divisor}) : trial[k][D-1:0];
      nq_n[k]  = {nq_s[k][N-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N - 1; k++) begin
        rem_q[k+1] <= rem_n[k];
      end
      for (int k = 0; k < N; k++) begin
        nq_q[k+1] <= nq_n[k];
      end
    end
  end

  assign quotient = nq_q[N];

endmodule

// File: rtl/core/isc_compose.sv
// Source pixel store, alpha blend and RGB565 packing stages.
// Depends on isc_pkg.
module isc_compose #(
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic [1:0]               mode,
  input  isc_pkg::front_t          front,
  input  logic [$clog2(DEPTH)-1:0] addr,
  output logic                     res_valid,
  output isc_pkg::out_item_t       res
);
  import isc_pkg::*;

  typedef enum logic [1:0] {SEL_BG, SEL_PIX, SEL_MIX} sel_t;

  logic [31:0] mem [0:DEPTH-1];

  logic        v4;
  logic        outside4;
  logic [23:0] bg4;
  logic [31:0] rdata;

  logic        v5;
  sel_t        sel5;
  logic [23:0] pix5;
  logic [23:0] bg5;
  logic [2:0][15:0] sum5;
  logic        outside_flag5;

  sel_t        sel_c;
  logic [7:0]  alpha;
  logic [7:0]  ialpha;
  logic [2:0][15:0] sum_c;
  logic [2:0][7:0]  mix_c;
  logic [16:0] acc [0:2];
  logic [23:0] color_c;

  always_ff @(posedge clk) begin
    if (en) begin
      if (front.we) begin
        mem[addr] <= front.wdata;
      end
      rdata <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= front.render;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      outside4 <= front.outside;
      bg4      <= front.bg;
    end
  end

  always_comb begin
    alpha  = rdata[7:0];
    ialpha = ALPHA_OPAQUE - alpha;
    for (int ch = 0; ch < 3; ch++) begin
      sum_c[ch] = {8'd0, rdata[31-8*ch -: 8]} * {8'd0, alpha} +
                  {8'd0, bg4[23-8*ch -: 8]} * {8'd0, ialpha};
    end
    priority if (outside4) begin
      sel_c = SEL_BG;
    end else if ((mode < MODE_ICON) || (alpha == ALPHA_OPAQUE)) begin
      sel_c = SEL_PIX;
    end else if (alpha == ALPHA_CLEAR) begin
      sel_c = SEL_BG;
    end else begin
      sel_c = SEL_MIX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sel5 <= sel_c;
      pix5 <= rdata[31:8];
      bg5  <= bg4;
      sum5 <= sum_c;
    end
  end

  // divide by 255, exact over the full blend range
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      acc[ch]   = {1'b0, sum5[ch]} + 17'd1 + {9'd0, sum5[ch][15:8]};
      mix_c[ch] = acc[ch][15:8];
    end
    unique case (sel5)
      SEL_BG:  color_c = bg5;
      SEL_PIX: color_c = pix5;
      SEL_MIX: color_c = {mix_c[0], mix_c[1], mix_c[2]};
      default: color_c = bg5;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.pixel_rgb565 <= pack565(color_c[23:16], color_c[15:8], color_c[7:0]);
      res.in_margin    <= (sel5 == SEL_BG) && (bg5 == color_c) && outside_flag5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      outside_flag5 <= outside4;
    end
  end

endmodule

// File: rtl/core/image_scale_composite_top.sv
// Top level of the nearest-neighbor scaler and compositor.
// Depends on isc_pkg, isc_if, isc_setup, isc_div_pipe, isc_compose, assert_macros.svh.
`include "assert_macros.svh"

// One transaction enters per clock while pix_in.ready is high (output not stalled, setup
// idle): a load writes one RGBA source pixel, a render returns one RGB565 pixel; throughput
// is one per cycle under that condition. The depth is set by the 29 one-bit stages of the
// dividers for column, row and gradient. After reset and after every configuration write the
// window setup runs (a serial 20-bit divide); input ready stays low until it completes.
module image_scale_composite_top #(
  parameter int SOURCE_WIDTH_MAX  = 128,
  parameter int SOURCE_HEIGHT_MAX = 128,
  parameter int OUTPUT_DIM_MAX    = 1024
) (
  input  logic        clk,
  input  logic        rst,
  isc_cfg_if.sink     cfg,
  isc_in_if.sink      pix_in,
  isc_out_if.source   pix_out
);
  import isc_pkg::*;

  localparam int DEPTH  = SOURCE_WIDTH_MAX * SOURCE_HEIGHT_MAX;
  localparam int ADDR_W = $clog2(DEPTH);

  typedef struct packed {
    logic        v;
    logic        act;
    logic [6:0]  col;
    logic [6:0]  row;
    logic [31:0] rgba;
    logic [2:0]  gneg;
  } side_t;

  geom_t geom;
  logic  busy;
  logic  en;

  logic     v1;
  in_item_t it1;

  side_t                  side2;
  logic [DIV_W-1:0]       xprod2, yprod2;
  logic [2:0][GMAG_W-1:0] gmag2;

  logic [OUT_DIM_W-1:0]   yraw, yc;
  logic [7:0]             gtop, gbot, gdiff;
  logic [2:0]             gneg_c;
  logic [2:0][GMAG_W-1:0] gmag_c;
  logic [DIV_W-1:0]       xprod_c, yprod_c;

  logic [DIV_W-1:0]       qx, qy;
  logic [2:0][DIV_W-1:0]  gq;
  side_t                  side_d [1:DIV_W];

  side_t                  sd;
  logic [SX_W-1:0]        sx_c, sy_c;
  logic [7:0]             gt3;
  logic [23:0]            bg_c;
  logic                   outside_c;
  logic                   in_store_c;
  logic [ADDR_W-1:0]      addr_c;

  front_t                 front3;
  logic [ADDR_W-1:0]      addr3;

  logic                   res_v;
  out_item_t              res;

  isc_setup #(
    .SOURCE_WIDTH_MAX (SOURCE_WIDTH_MAX),
    .SOURCE_HEIGHT_MAX(SOURCE_HEIGHT_MAX),
    .OUTPUT_DIM_MAX   (OUTPUT_DIM_MAX)
  ) u_setup (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .geom(geom),
    .busy(busy)
  );

  assign en = !res_v || !pix_out.valid || pix_out.ready;
  assign pix_in.ready = en && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= pix_in.valid && pix_in.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it1 <= pix_in.data;
    end
  end

  always_comb begin
    xprod_c = it1.out_col * geom.usew;
    yprod_c = it1.out_row * geom.useh;
    yraw = {1'b0, geom.row_ofs} + {1'b0, it1.out_row};
    yc = (yraw > geom.span) ? geom.span : yraw;
    gtop = '0;
    gbot = '0;
    gdiff = '0;
    for (int ch = 0; ch < 3; ch++) begin
      gtop = geom.colors[40-8*ch +: 8];
      gbot = geom.colors[16-8*ch +: 8];
      gneg_c[ch] = (gbot < gtop);
      gdiff = gneg_c[ch] ? (gtop - gbot) : (gbot - gtop);
      gmag_c[ch] = gdiff * yc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side2.v <= 1'b0;
    end else if (en) begin
      side2.v <= v1;
    end
    if (en) begin
      side2.act  <= it1.action;
      side2.col  <= it1.src_col;
      side2.row  <= it1.src_row;
      side2.rgba <= {it1.red, it1.green, it1.blue, it1.alpha};
      side2.gneg <= gneg_c;
      xprod2     <= xprod_c;
      yprod2     <= yprod_c;
      gmag2      <= gmag_c;
    end
  end

  isc_div_pipe #(.N(DIV_W), .D(OUT_DIM_W)) u_div_x (
    .clk(clk), .en(en), .dividend(xprod2), .divisor(geom.ow), .quotient(qx)
  );

  isc_div_pipe #(.N(DIV_W), .D(OUT_DIM_W)) u_div_y (
    .clk(clk), .en(en), .dividend(yprod2), .divisor(geom.oh), .quotient(qy)
  );

  for (genvar ch = 0; ch < 3; ch++) begin : g_grad
    isc_div_pipe #(.N(DIV_W), .D(OUT_DIM_W)) u_div_g (
      .clk     (clk),
      .en      (en),
      .dividend({{(DIV_W-GMAG_W){1'b0}}, gmag2[ch]}),
      .divisor (geom.span),
      .quotient(gq[ch])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= DIV_W; k++) begin
        side_d[k].v <= 1'b0;
      end
    end else if (en) begin
      side_d[1] <= side2;
      for (int k = 2; k <= DIV_W; k++) begin
        side_d[k] <= side_d[k-1];
      end
    end
  end

  always_comb begin
    sd = side_d[DIV_W];
    sx_c = {2'b00, qx} + {{(SX_W-OFS_W){geom.ox[OFS_W-1]}}, geom.ox};
    sy_c = {2'b00, qy} + {{(SX_W-OFS_W){geom.oy[OFS_W-1]}}, geom.oy};
    outside_c = geom.empty || (sx_c >= {{(SX_W-SRC_DIM_W){1'b0}}, geom.dw}) ||
                (sy_c >= {{(SX_W-SRC_DIM_W){1'b0}}, geom.dh});
    gt3 = '0;
    for (int ch = 0; ch < 3; ch++) begin
      gt3 = geom.colors[40-8*ch +: 8];
      bg_c[23-8*ch -: 8] = sd.gneg[ch] ? (gt3 - gq[ch][7:0]) : (gt3 + gq[ch][7:0]);
    end
    in_store_c = (32'(sd.col) < SOURCE_WIDTH_MAX) && (32'(sd.row) < SOURCE_HEIGHT_MAX);
    if (sd.act) begin
      addr_c = ADDR_W'(32'(sy_c[7:0]) * SOURCE_WIDTH_MAX + 32'(sx_c[7:0]));
    end else begin
      addr_c = ADDR_W'(32'(sd.row) * SOURCE_WIDTH_MAX + 32'(sd.col));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front3.render <= 1'b0;
      front3.we     <= 1'b0;
    end else if (en) begin
      front3.render <= sd.v && sd.act;
      front3.we     <= sd.v && !sd.act && in_store_c;
    end
    if (en) begin
      front3.outside <= outside_c;
      front3.bg      <= bg_c;
      front3.wdata   <= sd.rgba;
      addr3          <= addr_c;
    end
  end

  isc_compose #(.DEPTH(DEPTH)) u_compose (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .mode     (geom.mode),
    .front    (front3),
    .addr     (addr3),
    .res_valid(res_v),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_out.valid <= 1'b0;
    end else if (!pix_out.valid || pix_out.ready) begin
      pix_out.valid <= res_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!pix_out.valid || pix_out.ready) begin
      pix_out.data <= res;
    end
  end

  `ISC_ASSERT_NEXT(a_cfg_starts_setup, clk, rst, cfg.valid && cfg.ready, busy)
  `ISC_ASSERT(a_out_from_pipe, clk, rst, $rose(pix_out.valid) |-> $past(res_v))
  `ISC_ASSERT_NEXT(a_stall_holds, clk, rst, res_v && pix_out.valid && !pix_out.ready,
                   res_v && $stable(res))

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Testbench for image_scale_composite_top: loads source pixels, renders output pixels
// and checks every result against a behavioral scaler and compositor.
// Depends on isc_pkg, isc_if and the RTL of the block.
module tb;
  import isc_pkg::*;

  localparam int IDX_COLORS = 0;
  localparam int IDX_ROW_OFS = 1;
  localparam int IDX_SPAN = 2;
  localparam int IDX_SRC_W = 3;
  localparam int IDX_SRC_H = 4;
  localparam int IDX_OUT_W = 5;
  localparam int IDX_OUT_H = 6;
  localparam int IDX_MODE = 7;
  localparam int LATENCY = 40;

  logic clk;
  logic rst;
  isc_cfg_if cfg ();
  isc_in_if pix_in ();
  isc_out_if pix_out ();

  image_scale_composite_top dut (
    .clk(clk), .rst(rst), .cfg(cfg.sink), .pix_in(pix_in.sink), .pix_out(pix_out.source)
  );

  logic [47:0] colors;
  logic [9:0] row_ofs;
  logic [10:0] span_rows;
  logic [7:0] src_w, src_h;
  logic [10:0] out_w, out_h;
  logic [1:0] mode;
  logic [31:0] store [0:16383];
  bit written [0:16383];

  out_item_t pixel_q[$];
  int errors;
  int sent;
  int tsx, tsy;
  bit stop_drain;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("** image_scale_composite_top: FAILED **");
    $finish;
  end

  function automatic logic [15:0] to565(longint r, longint g, longint b);
    logic [15:0] v;
    v = {r[7:3], g[7:2], b[7:3]};
    return v;
  endfunction

  function automatic void apply_cfg(int idx, logic [47:0] v);
    case (idx)
      IDX_COLORS: colors = v;
      IDX_ROW_OFS: row_ofs = v[9:0];
      IDX_SPAN: span_rows = v[10:0];
      IDX_SRC_W: src_w = v[7:0];
      IDX_SRC_H: src_h = v[7:0];
      IDX_OUT_W: out_w = v[10:0];
      IDX_OUT_H: out_h = v[10:0];
      default: mode = v[1:0];
    endcase
  endfunction

  // Window geometry; returns 1 when (col,row) lands inside the source.
  function automatic bit sample_pos(int cx, int cy, output int sx, output int sy);
    longint dw, dh, ow, oh, uw, uh;
    bit use_x;
    dw = (src_w > 128) ? 128 : src_w;
    dh = (src_h > 128) ? 128 : src_h;
    if (dw == 0 || dh == 0) return 0;
    ow = (out_w < 1) ? 1 : (out_w > 1024) ? 1024 : out_w;
    oh = (out_h < 1) ? 1 : (out_h > 1024) ? 1024 : out_h;
    use_x = (mode == MODE_COVER) ? (dw * oh < dh * ow) : (dw * oh > dh * ow);
    if (use_x) begin
      uw = dw;
      uh = (2 * oh * dw + ow) / (2 * ow);
    end else begin
      uh = dh;
      uw = (2 * ow * dh + oh) / (2 * oh);
    end
    sx = int'((dw - uw) / 2 + cx * uw / ow);
    sy = int'((dh - uh) / 2 + cy * uh / oh);
    return !(sx < 0 || sy < 0 || sx >= dw || sy >= dh);
  endfunction

  function automatic out_item_t render_pixel(int cx, int cy);
    out_item_t o;
    longint span, y, t, b, a;
    longint bg [3];
    longint fg [3];
    int sx, sy;
    logic [31:0] px;
    span = (span_rows < 2) ? 239 : span_rows - 1;
    y = row_ofs + cy;
    if (y > span) y = span;
    for (int c = 0; c < 3; c++) begin
      t = colors[24 + 16 - 8 * c +: 8];
      b = colors[16 - 8 * c +: 8];
      bg[c] = t + (b - t) * y / span;
    end
    o.pixel_rgb565 = to565(bg[0], bg[1], bg[2]);
    o.in_margin = 1;
    if (!sample_pos(cx, cy, sx, sy)) return o;
    o.in_margin = 0;
    px = store[sy * 128 + sx];
    a = px[7:0];
    for (int c = 0; c < 3; c++) fg[c] = px[24 - 8 * c +: 8];
    if (mode < MODE_ICON || a == 255) o.pixel_rgb565 = to565(fg[0], fg[1], fg[2]);
    else if (a != 0) begin
      for (int c = 0; c < 3; c++) fg[c] = (fg[c] * a + bg[c] * (255 - a)) / 255;
      o.pixel_rgb565 = to565(fg[0], fg[1], fg[2]);
    end
    return o;
  endfunction

  task automatic write_reg(int idx, logic [47:0] v);
    cfg.index <= idx[2:0];
    cfg.wdata <= v;
    cfg.valid <= 1;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    apply_cfg(idx, v);
    @(negedge clk);
    cfg.valid <= 0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    int n;
    n = 0;
    while (pixel_q.size() != 0 && n < 200000) begin
      @(posedge clk);
      n++;
    end
    repeat (LATENCY) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return;
    pix_in.valid <= 0;
    if (r < 95) repeat ($urandom_range(1, 3)) @(negedge clk);
    else repeat ($urandom_range(10, 40)) @(negedge clk);
  endtask

  // Send one transaction; predict on acceptance. Caller holds the negedge phase.
  task automatic send(in_item_t it, bit burst);
    if (!burst) gap();
    pix_in.data <= it;
    pix_in.valid <= 1;
    @(posedge clk);
    while (!pix_in.ready) @(posedge clk);
    if (it.action) pixel_q.push_back(render_pixel(it.out_col, it.out_row));
    else begin
      store[{it.src_row, it.src_col}] = {it.red, it.green, it.blue, it.alpha};
      written[{it.src_row, it.src_col}] = 1;
    end
    sent++;
    @(negedge clk);
  endtask

  task automatic load_item(int c, int r, logic [31:0] v, bit burst);
    in_item_t it;
    it = '0;
    it.src_col = c[6:0];
    it.src_row = r[6:0];
    {it.red, it.green, it.blue, it.alpha} = v;
    it.action = 0;
    it.out_col = $urandom;
    it.out_row = $urandom;
    send(it, burst);
  endtask

  task automatic render_item(int c, int r, bit burst);
    in_item_t it;
    it = $urandom;
    it.red = $urandom;
    it.alpha = $urandom;
    it.action = 1;
    it.out_col = c[9:0];
    it.out_row = r[9:0];
    send(it, burst);
  endtask

  task automatic fill_source(bit burst);
    logic [31:0] v;
    for (int r = 0; r < src_h && r < 128; r++)
      for (int c = 0; c < src_w && c < 128; c++) begin
        v = $urandom;
        case ($urandom_range(0, 3))
          0: v[7:0] = ALPHA_CLEAR;
          1: v[7:0] = ALPHA_OPAQUE;
          default: ;
        endcase
        load_item(c, r, v, burst);
      end
  endtask

  // Only renders whose sample hits a written entry, or misses the source, are sent.
  function automatic bit safe(int c, int r);
    int sx, sy;
    if (!sample_pos(c, r, sx, sy)) return 1;
    return written[sy * 128 + sx];
  endfunction

  initial begin : drain
    int n;
    pix_out.ready = 0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      n = $urandom_range(0, 99);
      if (n == 0 && !stop_drain) begin
        pix_out.ready <= 0;
        repeat ($urandom_range(10, 40)) @(negedge clk);
        pix_out.ready <= 1;
      end else begin
        pix_out.ready <= (n >= 30) || stop_drain;
      end
    end
  end

  out_item_t got, want;
  always @(posedge clk) begin
    if (!rst && pix_out.valid && pix_out.ready) begin
      got = pix_out.data;
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected pixel %h/%0b", $time, got.pixel_rgb565, got.in_margin);
        errors++;
      end else begin
        want = pixel_q.pop_front();
        if (got.pixel_rgb565 !== want.pixel_rgb565) begin
          $display("%0t: pixel_rgb565 expected %h actual %h", $time,
                   want.pixel_rgb565, got.pixel_rgb565);
          errors++;
        end
        if (got.in_margin !== want.in_margin) begin
          $display("%0t: in_margin expected %0b actual %0b", $time,
                   want.in_margin, got.in_margin);
          errors++;
        end
      end
    end
  end

  typedef struct {
    logic [47:0] colors;
    int ofs, span, sw, sh, w, h, md, col, row;
    logic [15:0] pix;
    bit margin;
    bit typed;
  } row_t;

  row_t tbl [$];

  initial begin
    errors = 0;
    sent = 0;
    stop_drain = 0;
    rst = 1;
    cfg.valid = 0;
    cfg.index = '0;
    cfg.wdata = '0;
    pix_in.valid = 0;
    pix_in.data = '0;
    colors = 0; row_ofs = 0; span_rows = GRAD_SPAN_DEFAULT;
    src_w = 0; src_h = 0; out_w = 1; out_h = 1; mode = MODE_COVER;
    for (int i = 0; i < 16384; i++) begin
      store[i] = 0;
      written[i] = 0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // colors, ofs, span, sw, sh, w, h, mode, col, row, pix, margin, typed
    tbl = '{
      '{48'h0, 0, 240, 0, 0, 1, 1, 0, 0, 0, 16'h0000, 1, 1},
      '{48'hFFFFFF_FFFFFF, 0, 240, 0, 0, 1, 1, 0, 1023, 1023, 16'hFFFF, 1, 1},
      '{48'hFF0000_0000FF, 0, 2, 0, 0, 1, 1, 0, 0, 0, 16'hF800, 1, 1},
      '{48'hFF0000_0000FF, 1023, 2, 0, 0, 1, 1, 0, 0, 1023, 16'h001F, 1, 1},
      '{48'hFF0000_0000FF, 0, 0, 0, 0, 1, 1, 0, 0, 239, 16'h001F, 1, 1},
      '{48'h00FF00_00FF00, 0, 1024, 0, 5, 8, 8, 0, 3, 3, 16'h07E0, 1, 1},
      '{48'h123456_ABCDEF, 17, 1024, 8, 8, 8, 8, 0, 0, 0, 0, 0, 0},
      '{48'h123456_ABCDEF, 5, 100, 8, 8, 8, 8, 0, 7, 7, 0, 0, 0},
      '{48'h123456_ABCDEF, 5, 100, 8, 8, 8, 8, 0, 1023, 1023, 0, 0, 0},
      '{48'hABCDEF_123456, 0, 240, 8, 4, 16, 16, 0, 5, 9, 0, 0, 0},
      '{48'hABCDEF_123456, 0, 240, 8, 4, 16, 16, 1, 5, 1, 0, 0, 0},
      '{48'hABCDEF_123456, 0, 240, 8, 4, 16, 16, 1, 5, 9, 0, 0, 0},
      '{48'hABCDEF_123456, 0, 240, 8, 4, 16, 16, 2, 3, 7, 0, 0, 0},
      '{48'hABCDEF_123456, 0, 240, 8, 4, 16, 16, 3, 6, 8, 0, 0, 0},
      '{48'h0F0F0F_F0F0F0, 30, 240, 200, 200, 0, 2047, 2, 0, 500, 0, 0, 0},
      '{48'h0F0F0F_F0F0F0, 30, 240, 128, 1, 1024, 1, 1, 1023, 0, 0, 0, 0},
      '{48'h0F0F0F_F0F0F0, 30, 240, 1, 128, 1, 1024, 0, 0, 1023, 0, 0, 0},
      '{48'h0F0F0F_F0F0F0, 30, 240, 3, 7, 9, 5, 2, 8, 4, 0, 0, 0}
    };
    foreach (tbl[i]) begin
      write_reg(IDX_COLORS, tbl[i].colors);
      write_reg(IDX_ROW_OFS, tbl[i].ofs);
      write_reg(IDX_SPAN, tbl[i].span);
      write_reg(IDX_SRC_W, tbl[i].sw);
      write_reg(IDX_SRC_H, tbl[i].sh);
      write_reg(IDX_OUT_W, tbl[i].w);
      write_reg(IDX_OUT_H, tbl[i].h);
      write_reg(IDX_MODE, tbl[i].md);
      if (tbl[i].sw <= 16 && tbl[i].sh <= 16) fill_source(1);
      else if (sample_pos(tbl[i].col, tbl[i].row, tsx, tsy))
        load_item(tsx, tsy, $urandom, 1);
      if (tbl[i].typed) begin
        want.pixel_rgb565 = tbl[i].pix;
        want.in_margin = tbl[i].margin;
        if (render_pixel(tbl[i].col, tbl[i].row) !== want) begin
          $display("%0t: table row %0d expected %h/%0b actual %h/%0b", $time, i,
                   want.pixel_rgb565, want.in_margin,
                   render_pixel(tbl[i].col, tbl[i].row).pixel_rgb565,
                   render_pixel(tbl[i].col, tbl[i].row).in_margin);
          errors++;
        end
      end
      if (safe(tbl[i].col, tbl[i].row)) render_item(tbl[i].col, tbl[i].row, 0);
      pix_in.valid <= 0;
      wait_idle();
    end

    // Random phases: small sources, mostly renders over the canvas.
    while (sent < 1300) begin
      write_reg(IDX_COLORS, 48'({$urandom, $urandom}));
      write_reg(IDX_ROW_OFS, ($urandom_range(0, 3) == 0) ? 1023 : $urandom_range(0, 300));
      write_reg(IDX_SPAN, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2047)
                                                       : $urandom_range(2, 1024));
      write_reg(IDX_SRC_W, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                       : $urandom_range(1, 8));
      write_reg(IDX_SRC_H, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                       : $urandom_range(1, 8));
      write_reg(IDX_OUT_W, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                                       : $urandom_range(1, 40));
      write_reg(IDX_OUT_H, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                                       : $urandom_range(1, 40));
      write_reg(IDX_MODE, $urandom_range(0, 3));
      if (src_w <= 16 && src_h <= 16) fill_source($urandom_range(0, 3) == 0);
      for (int k = 0; k < 80; k++) begin
        int c, r;
        bit burst;
        burst = (k / 20) % 2 == 1;
        if ($urandom_range(0, 9) == 0) begin
          c = $urandom_range(0, 1023);
          r = $urandom_range(0, 1023);
        end else begin
          c = $urandom_range(0, (out_w < 1 ? 1 : out_w > 1024 ? 1024 : out_w) - 1);
          r = $urandom_range(0, (out_h < 1 ? 1 : out_h > 1024 ? 1024 : out_h) - 1);
        end
        if ($urandom_range(0, 19) == 0) load_item($urandom, $urandom, $urandom, burst);
        else if (safe(c, r)) render_item(c, r, burst);
      end
      pix_in.valid <= 0;
      wait_idle();
    end

    stop_drain = 1;
    wait_idle();
    if (errors == 0 && pixel_q.size() == 0) begin
      $display("** image_scale_composite_top: PASSED **");
    end else begin
      $display("** image_scale_composite_top: FAILED **");
    end
    $finish;
  end
endmodule
